[design/selectable_alphabet_radix64_codec_assert.svh]
// Assertion helpers for the radix-64 codec.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef SELECTABLE_ALPHABET_RADIX64_CODEC_ASSERT_SVH
`define SELECTABLE_ALPHABET_RADIX64_CODEC_ASSERT_SVH

// Same-cycle implication
`define SARC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SARC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sarc_pkg.sv]
`default_nettype none

package sarc_pkg;

    localparam int NUM_TABLES_DEF = 10;
    localparam int SEL_W          = 4;
    localparam int BYTE_W         = 8;
    localparam int IDX_W          = 6;
    localparam int ALPHA_LEN      = 64;
    localparam int LANES          = 4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_DECODE = 2'd2
    } op_t;

    localparam logic [2:0] CNT_ENCODE = 3'd4;
    localparam logic [2:0] CNT_DECODE = 3'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SEL_W-1:0]  table_sel;
        logic [IDX_W-1:0]  entry_index;
        logic [BYTE_W-1:0] entry_value;
        logic [BYTE_W-1:0] in_byte0;
        logic [BYTE_W-1:0] in_byte1;
        logic [BYTE_W-1:0] in_byte2;
        logic [BYTE_W-1:0] in_byte3;
    } req_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte0;
        logic [BYTE_W-1:0] out_byte1;
        logic [BYTE_W-1:0] out_byte2;
        logic [BYTE_W-1:0] out_byte3;
        logic [2:0]        out_count;
        logic [LANES-1:0]  bad_char_mask;
    } rsp_item_t;

    // write command for a position-map bank
    typedef struct packed {
        logic             en;
        logic             row_clr;
        logic [IDX_W-1:0] bit_idx;
        logic             bit_val;
    } map_wr_t;

    // address bits needed to pick one of n tables (at least 1)
    function automatic int tab_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

[design/sarc_store_bank.sv]
`default_nettype none

// One copy of the alphabet store: table x position -> character
module sarc_store_bank #(
    parameter int NUM_TABLES = sarc_pkg::NUM_TABLES_DEF,
    localparam int AW = sarc_pkg::tab_bits(NUM_TABLES) + sarc_pkg::IDX_W
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [sarc_pkg::BYTE_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [sarc_pkg::BYTE_W-1:0] wr_data
);
    import sarc_pkg::*;

    localparam int DEPTH = NUM_TABLES * ALPHA_LEN;

    logic [BYTE_W-1:0] store_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // single write port, registered read (old data on a same-address write)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/sarc_map_bank.sv]
`default_nettype none

// One copy of the position map: row (table, character) holds a bit per
// alphabet position that currently stores that character.
module sarc_map_bank #(
    parameter int NUM_TABLES = sarc_pkg::NUM_TABLES_DEF,
    localparam int AW = sarc_pkg::tab_bits(NUM_TABLES) + sarc_pkg::BYTE_W
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [sarc_pkg::ALPHA_LEN-1:0] rd_row,
    input  sarc_pkg::map_wr_t            wr,
    input  logic [AW-1:0]                wr_addr
);
    import sarc_pkg::*;

    localparam int DEPTH = NUM_TABLES * (1 << BYTE_W);

    logic [ALPHA_LEN-1:0] map_mem [DEPTH];
    logic [ALPHA_LEN-1:0] rd_row_reg;

    // whole-row clear for the reset sweep, otherwise a single-bit write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            if (wr.row_clr)
            begin
                map_mem[wr_addr] <= '0;
            end
            else
            begin
                map_mem[wr_addr][wr.bit_idx] <= wr.bit_val;
            end
        end
        if (rd_en)
        begin
            rd_row_reg <= map_mem[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

`default_nettype wire

[design/selectable_alphabet_radix64_codec.sv]
// Pipeline: an accepted item passes the s1, s2, s3 and s4 registers, then the output register.
// Throughput: one encode or decode item per cycle unless the output is held; a load
// leaves a bubble behind it, as it clears and then sets one bit of the position map.
// Reset: control state clears at once, then a sweep zeroes the position map one
// row a cycle, NUM_TABLES*256 rows (2560 by default), with req_ready low.
`default_nettype none

`include "selectable_alphabet_radix64_codec_assert.svh"

module selectable_alphabet_radix64_codec #(
    parameter int NUM_TABLES = sarc_pkg::NUM_TABLES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  sarc_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output sarc_pkg::rsp_item_t rsp_item
);
    import sarc_pkg::*;

    localparam int TW        = tab_bits(NUM_TABLES);
    localparam int SAW       = TW + IDX_W;
    localparam int MAW       = TW + BYTE_W;
    localparam int MAP_DEPTH = NUM_TABLES * (1 << BYTE_W);
    localparam logic [MAW-1:0]   MAP_LAST = MAW'(MAP_DEPTH - 1);
    localparam logic [SEL_W:0]   TAB_LIM  = (SEL_W + 1)'(NUM_TABLES);
    localparam int GRP = 8;

    // lowest set position of a map row: {hit, index}
    function automatic logic [IDX_W:0] lowest_set(input logic [ALPHA_LEN-1:0] row);
        logic [GRP-1:0]        grp_any;
        logic [GRP-1:0][2:0]   grp_lo;
        logic [2:0]            gsel;
        grp_any = '0;
        grp_lo  = '0;
        gsel    = '0;
        for (int g = 0; g < GRP; g++)
        begin
            grp_any[g] = |row[g*GRP +: GRP];
            for (int j = GRP - 1; j >= 0; j--)
            begin
                if (row[g*GRP + j])
                begin
                    grp_lo[g] = 3'(j);
                end
            end
        end
        for (int g = GRP - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                gsel = 3'(g);
            end
        end
        return {|grp_any, gsel, grp_lo[gsel]};
    endfunction

    function automatic logic [BYTE_W-1:0] lane_byte(input req_item_t it, input int unsigned i);
        logic [BYTE_W-1:0] b;
        unique case (i)
            0:       b = it.in_byte0;
            1:       b = it.in_byte1;
            2:       b = it.in_byte2;
            default: b = it.in_byte3;
        endcase
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic adv;
    logic accept;
    logic clr_busy_reg;
    logic [MAW-1:0] clr_addr_reg;

    logic      s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic      s1_ok_reg, s2_ok_reg, s3_ok_reg;
    req_item_t s1_item_reg, s2_item_reg, s3_item_reg;
    logic [1:0] s4_op_reg;
    logic [BYTE_W-1:0] s3_char_reg [LANES];
    logic [BYTE_W-1:0] s4_val_reg  [LANES];
    logic [LANES-1:0]  s4_mask_reg;
    logic      rsp_valid_reg;
    rsp_item_t rsp_item_reg;
    rsp_item_t rsp_next;

    logic s1_is_load, s2_is_load, s3_is_load;

    assign s1_is_load = (s1_item_reg.opcode == OP_LOAD);
    assign s2_is_load = (s2_item_reg.opcode == OP_LOAD);
    assign s3_is_load = (s3_item_reg.opcode == OP_LOAD);

    // whole pipe moves unless the output holds an item not taken
    assign adv       = !rsp_valid_reg || rsp_ready;
    // a load leaves a bubble behind it so its map writes never collide with those of a following load
    assign req_ready = adv && !clr_busy_reg && !(s1_valid_reg && s1_is_load);
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            rsp_valid_reg <= s4_valid_reg
                             && (s4_op_reg == OP_ENCODE || s4_op_reg == OP_DECODE);
        end
    end

    // map clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == MAP_LAST)
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: store access (load writes, encode reads, load reads old char)
    // ------------------------------------------------------------------
    logic [TW-1:0]    s1_tab;
    logic [IDX_W-1:0] enc_idx [LANES];
    logic [SAW-1:0]   st_raddr [LANES];
    logic [BYTE_W-1:0] st_rdata [LANES];
    logic             st_wr_en;

    assign s1_tab = s1_item_reg.table_sel[TW-1:0];

    // three bytes split into four 6-bit indices, high bits first
    assign enc_idx[0] = s1_item_reg.in_byte0[7:2];
    assign enc_idx[1] = {s1_item_reg.in_byte0[1:0], s1_item_reg.in_byte1[7:4]};
    assign enc_idx[2] = {s1_item_reg.in_byte1[3:0], s1_item_reg.in_byte2[7:6]};
    assign enc_idx[3] = s1_item_reg.in_byte2[5:0];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            st_raddr[i] = {s1_tab, enc_idx[i]};
        end
        if (s1_is_load)
        begin
            st_raddr[0] = {s1_tab, s1_item_reg.entry_index};
        end
    end

    assign st_wr_en = adv && s1_valid_reg && s1_is_load && s1_ok_reg;

    for (genvar gi = 0; gi < LANES; gi++)
    begin : g_store
        sarc_store_bank #(
            .NUM_TABLES (NUM_TABLES)
        ) u_store (
            .clk     (clk),
            .rd_en   (adv),
            .rd_addr (st_raddr[gi]),
            .rd_data (st_rdata[gi]),
            .wr_en   (st_wr_en),
            .wr_addr ({s1_tab, s1_item_reg.entry_index}),
            .wr_data (s1_item_reg.entry_value)
        );
    end

    // ------------------------------------------------------------------
    // Stage 2: map reads for decode, clear of the old character's bit on load
    // Stage 3: set of the new character's bit on load
    // ------------------------------------------------------------------
    logic [TW-1:0]        s2_tab, s3_tab;
    logic [MAW-1:0]       map_raddr [LANES];
    logic [ALPHA_LEN-1:0] map_rrow  [LANES];
    logic                 map_clr_en, map_set_en;
    map_wr_t              map_wr;
    logic [MAW-1:0]       map_waddr;

    assign s2_tab = s2_item_reg.table_sel[TW-1:0];
    assign s3_tab = s3_item_reg.table_sel[TW-1:0];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            map_raddr[i] = {s2_tab, lane_byte(s2_item_reg, i)};
        end
    end

    assign map_clr_en = adv && s2_valid_reg && s2_is_load && s2_ok_reg;
    assign map_set_en = adv && s3_valid_reg && s3_is_load && s3_ok_reg;

    always_comb
    begin
        map_wr    = '0;
        map_waddr = '0;
        priority if (clr_busy_reg)
        begin
            map_wr.en      = 1'b1;
            map_wr.row_clr = 1'b1;
            map_waddr      = clr_addr_reg;
        end
        else if (map_set_en)
        begin
            map_wr.en      = 1'b1;
            map_wr.bit_idx = s3_item_reg.entry_index;
            map_wr.bit_val = 1'b1;
            map_waddr      = {s3_tab, s3_item_reg.entry_value};
        end
        else if (map_clr_en)
        begin
            map_wr.en      = 1'b1;
            map_wr.bit_idx = s2_item_reg.entry_index;
            map_wr.bit_val = 1'b0;
            map_waddr      = {s2_tab, st_rdata[0]};
        end
        else
        begin
            // no map write this cycle
            map_wr.en = 1'b0;
        end
    end

    for (genvar gm = 0; gm < LANES; gm++)
    begin : g_map
        sarc_map_bank #(
            .NUM_TABLES (NUM_TABLES)
        ) u_map (
            .clk     (clk),
            .rd_en   (adv),
            .rd_addr (map_raddr[gm]),
            .rd_row  (map_rrow[gm]),
            .wr      (map_wr),
            .wr_addr (map_waddr)
        );
    end

    // ------------------------------------------------------------------
    // Stage 3: lowest matching position per character
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] s4_val_next [LANES];
    logic [LANES-1:0]  s4_mask_next;

    always_comb
    begin
        logic [IDX_W:0] hit_idx;
        logic           hit;
        for (int i = 0; i < LANES; i++)
        begin
            hit_idx = lowest_set(map_rrow[i]);
            hit     = hit_idx[IDX_W] && s3_ok_reg;
            if (s3_item_reg.opcode == OP_DECODE)
            begin
                // unmatched characters keep their raw byte
                s4_val_next[i]  = hit ? {2'b00, hit_idx[IDX_W-1:0]}
                                      : lane_byte(s3_item_reg, i);
                s4_mask_next[i] = !hit;
            end
            else
            begin
                s4_val_next[i]  = s3_ok_reg ? s3_char_reg[i] : '0;
                s4_mask_next[i] = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pack decoded values into three bytes, or pass four encoded characters as bytes
    // ------------------------------------------------------------------
    always_comb
    begin
        rsp_next = '0;
        if (s4_op_reg == OP_DECODE)
        begin
            // right shifts copy bit 7 of an unmatched raw character
            rsp_next.out_byte0 = {s4_val_reg[0][5:0], 2'b00}
                                 | {{4{s4_val_reg[1][7]}}, s4_val_reg[1][7:4]};
            rsp_next.out_byte1 = {s4_val_reg[1][3:0], 4'b0000}
                                 | {{2{s4_val_reg[2][7]}}, s4_val_reg[2][7:2]};
            rsp_next.out_byte2 = {s4_val_reg[2][1:0], 6'b000000} | s4_val_reg[3];
            rsp_next.out_byte3 = '0;
            rsp_next.out_count = CNT_DECODE;
            rsp_next.bad_char_mask = s4_mask_reg;
        end
        else
        begin
            rsp_next.out_byte0 = s4_val_reg[0];
            rsp_next.out_byte1 = s4_val_reg[1];
            rsp_next.out_byte2 = s4_val_reg[2];
            rsp_next.out_byte3 = s4_val_reg[3];
            rsp_next.out_count = CNT_ENCODE;
            rsp_next.bad_char_mask = '0;
        end
    end

    // payload registers, moved with the pipe
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= req_item;
            s1_ok_reg   <= ({1'b0, req_item.table_sel} < TAB_LIM);
            s2_item_reg <= s1_item_reg;
            s2_ok_reg   <= s1_ok_reg;
            s3_item_reg <= s2_item_reg;
            s3_ok_reg   <= s2_ok_reg;
            s4_op_reg   <= s3_item_reg.opcode;
            s4_mask_reg <= s4_mask_next;
            for (int i = 0; i < LANES; i++)
            begin
                s3_char_reg[i] <= st_rdata[i];
                s4_val_reg[i]  <= s4_val_next[i];
            end
            rsp_item_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SARC_ASSERT_IMP(a_map_one_write, map_set_en, !map_clr_en, "two map writes in one cycle")
    `SARC_ASSERT_IMP(a_sweep_pipe_empty, clr_busy_reg,
        !(s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg || rsp_valid_reg),
        "item in flight during map sweep")
    `SARC_ASSERT_NXT(a_load_bubble, s1_valid_reg && s1_is_load && adv, !s1_valid_reg,
        "no bubble behind a load")
    `SARC_ASSERT_IMP(a_decode_shape,
        rsp_valid_reg && rsp_item_reg.out_count == CNT_DECODE,
        rsp_item_reg.out_byte3 == '0, "decode result with nonzero fourth byte")

endmodule

`default_nettype wire
